>>> src/nec_ir_pkg.sv
`default_nettype none

package nec_ir_pkg;

	localparam int unsigned DUR_W  = 16;
	localparam int unsigned UNIT_W = 12;
	localparam int unsigned TOL_W  = 8;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [UNIT_W-1:0] UNIT_RESET   = 12'd564;
	localparam logic [TOL_W-1:0]  TOL_RESET    = 8'd77;
	localparam logic [DUR_W-1:0]  ENDING_RESET = 16'd20000;

	localparam logic [POS_W-1:0] POS_MAX         = 7'd127;
	localparam logic [POS_W-1:0] POS_LEAD_FLASH  = 7'd0;
	localparam logic [POS_W-1:0] POS_LEAD_GAP    = 7'd1;
	localparam logic [POS_W-1:0] POS_REP_FLASH   = 7'd2;
	localparam logic [POS_W-1:0] POS_REP_LAST    = 7'd3;
	localparam logic [POS_W-1:0] POS_LAST_BIT    = 7'd65;
	localparam logic [POS_W-1:0] POS_STOP_FLASH  = 7'd66;
	localparam logic [POS_W-1:0] POS_FRAME_LAST  = 7'd67;
	localparam logic [BYTE_W-1:0] BYTE_ALL_ONES  = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNIT_TIME  = 2'd0,
		REG_TOLERANCE  = 2'd1,
		REG_ENDING_MIN = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BYTE_DEVICE    = 2'd0,
		BYTE_SUBDEVICE = 2'd1,
		BYTE_COMMAND   = 2'd2,
		BYTE_INVERSE   = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic              frame_valid;
		logic              is_repeat;
		logic [BYTE_W-1:0] device;
		logic [BYTE_W-1:0] subdevice;
		logic [BYTE_W-1:0] command;
	} frame_res_t;

	function automatic logic near_units(
		input logic [DUR_W-1:0] d,
		input logic [DUR_W-1:0] exp_us,
		input logic [DUR_W-1:0] slack
	);
		logic [DUR_W-1:0] diff;
		diff = (d > exp_us) ? (d - exp_us) : (exp_us - d);
		return diff <= slack;
	endfunction

endpackage

`default_nettype wire

>>> src/nec_ir_if.sv
`default_nettype none

interface nec_ir_dur_if import nec_ir_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] duration_us;
	logic             last_duration;

	modport source(output valid, duration_us, last_duration, input ready);
	modport sink(input valid, duration_us, last_duration, output ready);
endinterface

interface nec_ir_frm_if import nec_ir_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              frame_valid;
	logic              is_repeat;
	logic [BYTE_W-1:0] device;
	logic [BYTE_W-1:0] subdevice;
	logic [BYTE_W-1:0] command;

	modport source(output valid, frame_valid, is_repeat, device, subdevice, command,
		input ready);
	modport sink(input valid, frame_valid, is_repeat, device, subdevice, command,
		output ready);
endinterface

`default_nettype wire

>>> src/nec_ir_frame_decoder.sv
// NEC1 infrared frame decoder.
// durations: one captured flash or gap length per item, flash first, with
//   last_duration set on the final duration of a capture.
// frames: one item per capture, sent on its last duration: frame_valid,
//   is_repeat and the device, subdevice and command bytes (all zero when
//   the capture is not a valid frame or repeat).
// Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 unit time, 1 tolerance in 1/256, 2 minimum ending gap); other indexes
//   are ignored. Write only while no capture is in progress.
// Timing: an item is registered at acceptance, checked against the unit
//   multiples in the next cycle, and a last duration's result goes into the
//   output register, which drives frames.valid, when free. One duration
//   per cycle is taken unless a last one waits; the single multiply unit time
//   by tolerance plus one compare per multiple sets the cycle path.
// Reset: registers return to 564 us, 77/256 and 20000 us, capture state is
//   cleared and no output item is pending.
// Stall: a held output item keeps the input stage moving for durations that
//   produce no result; only a last duration waits for the output register.
`default_nettype none

module nec_ir_frame_decoder import nec_ir_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	nec_ir_dur_if.sink                 durations,
	nec_ir_frm_if.source               frames
);

	logic [UNIT_W-1:0] unit_q;
	logic [TOL_W-1:0]  tol_q;
	logic [DUR_W-1:0]  ending_q;

	logic             valid_s1;
	logic [DUR_W-1:0] dur_s1;
	logic             last_s1;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] shift_q;
	logic [BYTE_W-1:0] dev_q;
	logic [BYTE_W-1:0] sub_q;
	logic [BYTE_W-1:0] cmd_q;
	logic              flash_ok_q;
	logic              frame_ok_q;
	logic              rep_ok_q;

	logic       out_valid_q;
	frame_res_t res_q;

	logic out_free;
	logic adv_s1;
	logic load_res;

	logic [UNIT_W+TOL_W-1:0] prod;
	logic [23:0] slack_prod1, slack_prod3, slack_prod4, slack_prod8, slack_prod16;
	logic [DUR_W-1:0] exp1, exp3, exp4, exp8, exp16;
	logic m1, m3, m4, m8, m16;

	logic [POS_W-1:0]  pos_n;
	logic [BYTE_W-1:0] shift_n, dev_n, sub_n, cmd_n;
	logic              flash_ok_n, frame_ok_n, rep_ok_n;
	logic              bit_v;
	logic [POS_W-1:0]  idx_full;
	logic [4:0]        idx;
	logic              ending_ok;
	frame_res_t        res_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= UNIT_RESET;
			tol_q    <= TOL_RESET;
			ending_q <= ENDING_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNIT_TIME:  unit_q   <= cfg_data[UNIT_W-1:0];
				REG_TOLERANCE:  tol_q    <= cfg_data[TOL_W-1:0];
				REG_ENDING_MIN: ending_q <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free        = !out_valid_q || frames.ready;
	assign adv_s1          = valid_s1 && (!last_s1 || out_free);
	assign load_res        = adv_s1 && last_s1;
	assign durations.ready = !valid_s1 || adv_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (durations.ready) begin
			valid_s1 <= durations.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (durations.valid && durations.ready) begin
			dur_s1  <= durations.duration_us;
			last_s1 <= durations.last_duration;
		end
	end

	// expected durations and slack for each unit multiple
	always_comb begin
		prod         = unit_q * tol_q;
		slack_prod1  = {4'd0, prod};
		slack_prod3  = {3'd0, prod, 1'b0} + {4'd0, prod};
		slack_prod4  = {2'd0, prod, 2'd0};
		slack_prod8  = {1'd0, prod, 3'd0};
		slack_prod16 = {prod, 4'd0};
		exp1  = {4'd0, unit_q};
		exp3  = {3'd0, unit_q, 1'b0} + {4'd0, unit_q};
		exp4  = {2'd0, unit_q, 2'd0};
		exp8  = {1'd0, unit_q, 3'd0};
		exp16 = {unit_q, 4'd0};
		m1  = near_units(dur_s1, exp1,  slack_prod1[23:8]);
		m3  = near_units(dur_s1, exp3,  slack_prod3[23:8]);
		m4  = near_units(dur_s1, exp4,  slack_prod4[23:8]);
		m8  = near_units(dur_s1, exp8,  slack_prod8[23:8]);
		m16 = near_units(dur_s1, exp16, slack_prod16[23:8]);
	end

	// capture tracking
	always_comb begin
		shift_n    = shift_q;
		dev_n      = dev_q;
		sub_n      = sub_q;
		cmd_n      = cmd_q;
		flash_ok_n = flash_ok_q;
		frame_ok_n = frame_ok_q;
		rep_ok_n   = rep_ok_q;
		bit_v      = 1'b0;
		idx_full   = pos_q - 7'd3;
		idx        = idx_full[5:1];

		if (pos_q == POS_LEAD_FLASH) begin
			if (!m16) begin
				frame_ok_n = 1'b0;
				rep_ok_n   = 1'b0;
			end
		end else if (pos_q == POS_LEAD_GAP) begin
			if (!m8)
				frame_ok_n = 1'b0;
			if (!m4)
				rep_ok_n = 1'b0;
		end else if (pos_q <= POS_LAST_BIT) begin
			if (pos_q == POS_REP_FLASH && !m1)
				rep_ok_n = 1'b0;
			if (!pos_q[0]) begin
				flash_ok_n = m1;
			end else begin
				if (!flash_ok_q)
					frame_ok_n = 1'b0;
				else if (m3)
					bit_v = 1'b1;
				else if (!m1)
					frame_ok_n = 1'b0;
				shift_n = {bit_v, shift_q[BYTE_W-1:1]};
				if (idx[2:0] == 3'd7) begin
					case (byte_sel_t'(idx[4:3]))
						BYTE_DEVICE:    dev_n = shift_n;
						BYTE_SUBDEVICE: sub_n = shift_n;
						BYTE_COMMAND:   cmd_n = shift_n;
						BYTE_INVERSE: begin
							if ((cmd_q ^ shift_n) != BYTE_ALL_ONES)
								frame_ok_n = 1'b0;
						end
						default: ;
					endcase
				end
			end
		end else if (pos_q == POS_STOP_FLASH) begin
			if (!m1)
				frame_ok_n = 1'b0;
		end

		pos_n = (pos_q < POS_MAX) ? (pos_q + 7'd1) : pos_q;

		ending_ok = dur_s1 >= ending_q;
		res_n     = '0;
		if (pos_q == POS_REP_LAST && rep_ok_n && ending_ok) begin
			res_n.frame_valid = 1'b1;
			res_n.is_repeat   = 1'b1;
		end else if (pos_q == POS_FRAME_LAST && frame_ok_n && ending_ok) begin
			res_n.frame_valid = 1'b1;
			res_n.device      = dev_n;
			res_n.subdevice   = sub_n;
			res_n.command     = cmd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			shift_q    <= '0;
			dev_q      <= '0;
			sub_q      <= '0;
			cmd_q      <= '0;
			flash_ok_q <= 1'b0;
			frame_ok_q <= 1'b1;
			rep_ok_q   <= 1'b1;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q      <= '0;
				shift_q    <= '0;
				dev_q      <= '0;
				sub_q      <= '0;
				cmd_q      <= '0;
				flash_ok_q <= 1'b0;
				frame_ok_q <= 1'b1;
				rep_ok_q   <= 1'b1;
			end else begin
				pos_q      <= pos_n;
				shift_q    <= shift_n;
				dev_q      <= dev_n;
				sub_q      <= sub_n;
				cmd_q      <= cmd_n;
				flash_ok_q <= flash_ok_n;
				frame_ok_q <= frame_ok_n;
				rep_ok_q   <= rep_ok_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res)
			res_q <= res_n;
	end

	assign frames.valid       = out_valid_q;
	assign frames.frame_valid = res_q.frame_valid;
	assign frames.is_repeat   = res_q.is_repeat;
	assign frames.device      = res_q.device;
	assign frames.subdevice   = res_q.subdevice;
	assign frames.command     = res_q.command;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (pos_q == '0) && frame_ok_q && rep_ok_q && !flash_ok_q)
		else $error("capture state not cleared after last item");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!durations.ready |-> valid_s1 && last_s1 && out_valid_q && !frames.ready)
		else $error("input stalled without a pending result");

	a_repeat_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.is_repeat |-> res_q.frame_valid && (res_q.device == '0)
			&& (res_q.subdevice == '0) && (res_q.command == '0))
		else $error("repeat item carries data");

	a_invalid_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.frame_valid |-> !res_q.is_repeat && (res_q.device == '0)
			&& (res_q.subdevice == '0) && (res_q.command == '0))
		else $error("invalid item carries data");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import nec_ir_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 540;
	localparam int unsigned PHASES = 6;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nec_ir_dur_if durations ();
	nec_ir_frm_if frames ();

	nec_ir_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.durations(durations),
		.frames(frames)
	);

	// decoder copy: registers and capture state
	logic [UNIT_W-1:0] unit_us;
	logic [TOL_W-1:0] tol_frac;
	logic [DUR_W-1:0] end_min_us;
	logic [POS_W-1:0] cap_pos;
	logic [BYTE_W-1:0] shift_reg;
	logic [BYTE_W-1:0] dev_byte;
	logic [BYTE_W-1:0] sub_byte;
	logic [BYTE_W-1:0] cmd_byte;
	logic flash_good;
	logic frame_good;
	logic ditto_good;

	frame_res_t expected_frames[$];
	logic [DUR_W-1:0] capture_q[$];

	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned frames_predicted = 0;
	int unsigned frames_checked = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 0;
	int unsigned burst_left = 0;
	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$error("run stopped after %0d cycles, %0d frames outstanding", cycles,
			expected_frames.size());
		$display("tb_top: errors");
		$finish;
	end

	function automatic bit matches_units(input logic [DUR_W-1:0] d, input int unsigned m);
		int unsigned target;
		int unsigned slack;
		int unsigned diff;
		target = m * unit_us;
		slack = (target * tol_frac) >> 8;
		diff = (d > target) ? (d - target) : (target - d);
		return diff <= slack;
	endfunction

	task automatic clear_capture_state();
		cap_pos = '0;
		shift_reg = '0;
		dev_byte = '0;
		sub_byte = '0;
		cmd_byte = '0;
		flash_good = 1'b0;
		frame_good = 1'b1;
		ditto_good = 1'b1;
	endtask

	task automatic decode_duration(input logic [DUR_W-1:0] d, input logic last);
		logic [POS_W-1:0] p;
		int unsigned idx;
		logic one_bit;
		frame_res_t res;
		p = cap_pos;
		if (p == POS_LEAD_FLASH) begin
			if (!matches_units(d, 16)) frame_good = 1'b0;
		end else if (p == POS_LEAD_GAP) begin
			if (!matches_units(d, 8)) frame_good = 1'b0;
		end else if (p <= POS_LAST_BIT) begin
			if (!p[0]) begin
				flash_good = matches_units(d, 1);
			end else begin
				one_bit = 1'b0;
				idx = (p - 3) >> 1;
				if (!flash_good) frame_good = 1'b0;
				else if (matches_units(d, 3)) one_bit = 1'b1;
				else if (!matches_units(d, 1)) frame_good = 1'b0;
				shift_reg = {one_bit, shift_reg[BYTE_W-1:1]};
				if (idx[2:0] == 3'd7) begin
					case (byte_sel_t'(idx[4:3]))
						BYTE_DEVICE: dev_byte = shift_reg;
						BYTE_SUBDEVICE: sub_byte = shift_reg;
						BYTE_COMMAND: cmd_byte = shift_reg;
						BYTE_INVERSE: begin
							if ((cmd_byte ^ shift_reg) != BYTE_ALL_ONES) frame_good = 1'b0;
						end
						default: ;
					endcase
				end
			end
		end else if (p == POS_STOP_FLASH) begin
			if (!matches_units(d, 1)) frame_good = 1'b0;
		end

		if (p == POS_LEAD_FLASH) begin
			if (!matches_units(d, 16)) ditto_good = 1'b0;
		end else if (p == POS_LEAD_GAP) begin
			if (!matches_units(d, 4)) ditto_good = 1'b0;
		end else if (p == POS_REP_FLASH) begin
			if (!matches_units(d, 1)) ditto_good = 1'b0;
		end

		if (cap_pos != POS_MAX) cap_pos = cap_pos + 1'b1;
		if (last) begin
			res = '0;
			if (p == POS_REP_LAST && ditto_good && d >= end_min_us) begin
				res.frame_valid = 1'b1;
				res.is_repeat = 1'b1;
			end else if (p == POS_FRAME_LAST && frame_good && d >= end_min_us) begin
				res.frame_valid = 1'b1;
				res.device = dev_byte;
				res.subdevice = sub_byte;
				res.command = cmd_byte;
			end
			expected_frames.push_back(res);
			frames_predicted++;
			clear_capture_state();
		end
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		frame_res_t want;
		if (frames.valid === 1'b1 && frames.ready === 1'b1) begin
			if (expected_frames.size() == 0) begin
				$error("frame item with none pending: valid %0b repeat %0b dev %0h sub %0h cmd %0h",
					frames.frame_valid, frames.is_repeat, frames.device, frames.subdevice,
					frames.command);
				mismatches++;
			end else begin
				want = expected_frames.pop_front();
				frames_checked++;
				check_field("frame_valid", want.frame_valid, frames.frame_valid);
				check_field("is_repeat", want.is_repeat, frames.is_repeat);
				check_field("device", want.device, frames.device);
				check_field("subdevice", want.subdevice, frames.subdevice);
				check_field("command", want.command, frames.command);
			end
		end
	end

	initial begin
		int unsigned hold;
		hold = 0;
		frames.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!receiver_stalls_on) begin
				frames.ready <= 1'b1;
			end else if (hold != 0) begin
				hold--;
				frames.ready <= 1'b0;
			end else if ($urandom_range(3, 0) == 0) begin
				hold = $urandom_range(20, 0);
				frames.ready <= 1'b0;
			end else begin
				frames.ready <= 1'b1;
			end
		end
	end

	task automatic send_duration(input logic [DUR_W-1:0] d, input logic last);
		int unsigned gap;
		if (sender_gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = $urandom_range(8, 1);
			@(negedge clk);
			durations.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left != 0) burst_left--;
		@(negedge clk);
		durations.valid <= 1'b1;
		durations.duration_us <= d;
		durations.last_duration <= last;
		do @(posedge clk); while (durations.ready !== 1'b1);
		decode_duration(d, last);
		items_sent++;
	endtask

	task automatic send_capture();
		int unsigned n;
		n = capture_q.size();
		for (int unsigned i = 0; i < n; i++) send_duration(capture_q[i], i == n - 1);
		capture_q.delete();
	endtask

	// hold the sender until every pending frame has come out
	task automatic settle();
		@(negedge clk);
		durations.valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_UNIT_TIME: unit_us = data[UNIT_W-1:0];
			REG_TOLERANCE: tol_frac = data[TOL_W-1:0];
			REG_ENDING_MIN: end_min_us = data[DUR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// upper data bits are random, the register keeps only its own width
	task automatic configure(input logic [UNIT_W-1:0] unit, input logic [TOL_W-1:0] tol,
		input logic [DUR_W-1:0] ending);
		settle();
		write_reg(REG_UNIT_TIME, {4'($urandom_range(15, 0)), unit});
		write_reg(REG_TOLERANCE, {8'($urandom_range(255, 0)), tol});
		write_reg(REG_ENDING_MIN, ending);
		settings_used++;
	endtask

	function automatic logic [DUR_W-1:0] near_dur(input int unsigned m);
		int unsigned target;
		int unsigned slack;
		int unsigned lo;
		int unsigned hi;
		target = m * unit_us;
		slack = (target * tol_frac) >> 8;
		lo = (target > slack) ? target - slack : 0;
		hi = target + slack;
		if (hi > 65535) hi = 65535;
		return DUR_W'($urandom_range(hi, lo));
	endfunction

	function automatic logic [DUR_W-1:0] end_dur(input bit good);
		if (good) return DUR_W'($urandom_range(65535, end_min_us));
		if (end_min_us == 0) return '0;
		return DUR_W'($urandom_range(end_min_us - 1, 0));
	endfunction

	task automatic push_frame(input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] sub,
		input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] inv, input bit good_end);
		logic [31:0] word;
		word = {inv, cmd, sub, dev};
		capture_q.push_back(near_dur(16));
		capture_q.push_back(near_dur(8));
		for (int i = 0; i < 32; i++) begin
			capture_q.push_back(near_dur(1));
			capture_q.push_back(near_dur(word[i] ? 3 : 1));
		end
		capture_q.push_back(near_dur(1));
		capture_q.push_back(end_dur(good_end));
	endtask

	task automatic push_repeat(input bit good_end);
		capture_q.push_back(near_dur(16));
		capture_q.push_back(near_dur(4));
		capture_q.push_back(near_dur(1));
		capture_q.push_back(end_dur(good_end));
	endtask

	task automatic push_noise(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(1, 0) == 0) capture_q.push_back(DUR_W'($urandom_range(65535, 0)));
			else capture_q.push_back(near_dur($urandom_range(16, 1)));
		end
	endtask

	task automatic test_reset_defaults();
		receiver_stalls_on = 1'b0;
		sender_gaps_on = 1'b0;
		push_repeat(1'b1);
		send_capture();
		push_frame(8'h00, 8'hFF, 8'h5A, 8'hA5, 1'b1);
		send_capture();
		push_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
		send_capture();
		push_repeat(1'b0);
		send_capture();
		settle();
	endtask

	task automatic test_short_captures();
		receiver_stalls_on = 1'b1;
		sender_gaps_on = 1'b1;
		capture_q.push_back(16'hFFFF);
		send_capture();
		capture_q.push_back(16'h0000);
		capture_q.push_back(16'hFFFF);
		send_capture();
		// ending gap exactly at the minimum, then one below
		push_repeat(1'b1);
		capture_q[3] = end_min_us;
		send_capture();
		push_repeat(1'b1);
		capture_q[3] = end_min_us - 1'b1;
		send_capture();
		capture_q.push_back(16'h0000);
		capture_q.push_back(16'hFFFF);
		capture_q.push_back(16'h0000);
		capture_q.push_back(16'hFFFF);
		send_capture();
		settle();
	endtask

	task automatic test_inverse_mismatch();
		push_frame(8'h12, 8'h34, 8'h56, ~8'h56 ^ 8'h01, 1'b1);
		send_capture();
		push_frame(8'h12, 8'h34, 8'h56, 8'h56, 1'b1);
		send_capture();
		settle();
	endtask

	// with full tolerance a mid gap fits both one and three units
	task automatic test_ambiguous_gap();
		logic [31:0] word;
		configure(UNIT_RESET, 8'd255, ENDING_RESET);
		word = {8'h69, 8'h96, 8'hC3, 8'h3C};
		capture_q.push_back(near_dur(16));
		capture_q.push_back(near_dur(8));
		for (int i = 0; i < 32; i++) begin
			capture_q.push_back(16'd564);
			capture_q.push_back(word[i] ? 16'd846 : 16'd4);
		end
		capture_q.push_back(16'd564);
		capture_q.push_back(16'd30000);
		send_capture();
		push_frame(8'h3C, 8'hC3, 8'h96, 8'h69, 1'b1);
		send_capture();
		configure(UNIT_RESET, TOL_RESET, ENDING_RESET);
	endtask

	task automatic test_overlong_capture();
		push_frame(8'hA0, 8'h0A, 8'h33, 8'hCC, 1'b1);
		void'(capture_q.pop_back());
		push_noise(62);
		capture_q.push_back(end_dur(1'b1));
		send_capture();
		push_repeat(1'b1);
		send_capture();
		settle();
	endtask

	task automatic test_zero_unit();
		configure('0, TOL_RESET, '0);
		push_repeat(1'b1);
		send_capture();
		push_frame(8'h01, 8'h02, 8'h03, 8'hFC, 1'b1);
		send_capture();
		push_repeat(1'b1);
		capture_q[2] = 16'd1;
		send_capture();
		configure(UNIT_RESET, TOL_RESET, ENDING_RESET);
	endtask

	task automatic test_unused_register();
		settle();
		write_reg(REG_UNUSED, 16'h0001);
		push_repeat(1'b1);
		send_capture();
		push_frame(8'h80, 8'h01, 8'h7F, 8'h80, 1'b1);
		send_capture();
		settle();
	endtask

	task automatic random_capture();
		int unsigned kind;
		int unsigned sel;
		int unsigned n;
		logic [BYTE_W-1:0] cmd;
		kind = $urandom_range(99, 0);
		cmd = BYTE_W'($urandom_range(255, 0));
		if (kind < 40) begin
			push_frame(BYTE_W'($urandom_range(255, 0)), BYTE_W'($urandom_range(255, 0)), cmd, ~cmd,
				$urandom_range(9, 0) != 0);
		end else if (kind < 65) begin
			push_repeat($urandom_range(9, 0) != 0);
		end else if (kind < 80) begin
			sel = $urandom_range(3, 0);
			push_frame(BYTE_W'($urandom_range(255, 0)), BYTE_W'($urandom_range(255, 0)), cmd,
				(sel == 3) ? BYTE_W'($urandom_range(255, 0)) : ~cmd, $urandom_range(4, 0) != 0);
			n = capture_q.size();
			if (sel == 0) begin
				capture_q[$urandom_range(n - 1, 0)] = DUR_W'($urandom_range(65535, 0));
			end else if (sel == 1) begin
				n = $urandom_range(n - 2, 1);
				while (capture_q.size() > n) void'(capture_q.pop_back());
				capture_q.push_back(end_dur(1'b1));
			end else if (sel == 2) begin
				void'(capture_q.pop_back());
				push_noise($urandom_range(6, 1));
				capture_q.push_back(end_dur(1'b1));
			end
		end else if (kind < 88) begin
			push_repeat(1'b1);
			capture_q[$urandom_range(3, 0)] = DUR_W'($urandom_range(65535, 0));
		end else begin
			push_noise(($urandom_range(9, 0) == 0) ? $urandom_range(140, 69) : $urandom_range(8, 1));
		end
		send_capture();
	endtask

	task automatic test_random_traffic();
		int unsigned items_start;
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(UNIT_RESET, TOL_RESET, ENDING_RESET);
				1: configure(12'd1, 8'd255, 16'd0);
				2: configure(12'd4095, 8'd0, 16'd65535);
				3: configure(12'd4095, 8'd255, 16'd0);
				4: configure(12'd1, 8'd0, 16'd65535);
				default: configure(UNIT_W'($urandom_range(1200, 200)), TOL_W'($urandom_range(255, 0)),
					DUR_W'($urandom_range(40000, 0)));
			endcase
			sender_gaps_on = (ph != 2);
			receiver_stalls_on = (ph != 4);
			items_start = items_sent;
			while (items_sent - items_start < RANDOM_ITEMS / PHASES) begin
				random_capture();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		durations.valid = 1'b0;
		durations.duration_us = '0;
		durations.last_duration = 1'b0;
		unit_us = UNIT_RESET;
		tol_frac = TOL_RESET;
		end_min_us = ENDING_RESET;
		clear_capture_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_short_captures();
		test_inverse_mismatch();
		test_ambiguous_gap();
		test_overlong_capture();
		test_zero_unit();
		test_unused_register();
		test_random_traffic();
		settle();

		$display("summary: %0d durations sent, %0d frame items predicted, %0d checked",
			items_sent, frames_predicted, frames_checked);
		$display("summary: %0d register settings, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

>>> sim.f
src/nec_ir_pkg.sv
src/nec_ir_if.sv
src/nec_ir_frame_decoder.sv
tb/sv/tb_top.sv
